// ===== rtl/dpp_pkg.sv =====
// Shared constants and types for the detector event packet parser.
package dpp_pkg;

  localparam int DVD_W   = 16;  // byte offset within a packet
  localparam int DVR_W   = 12;  // module block size in bytes
  localparam int QSAT_W  = 6;   // saturated module index, holds 0..32
  localparam int CNT_W   = 5;   // divider step counter

  localparam logic [CNT_W-1:0]  DIV_STEPS  = CNT_W'(DVD_W);
  localparam logic [QSAT_W-1:0] MOD_LIMIT  = 6'd32;
  localparam logic [10:0]       CH_LIMIT   = 11'd1024;
  localparam logic [16:0]       LEN_LIMIT  = 17'h10000;
  localparam logic [16:0]       DMIN_RESET = 17'h10000;

  localparam logic [1:0] CFG_HEADER_BYTES   = 2'd0;
  localparam logic [1:0] CFG_MODULE_COUNT   = 2'd1;
  localparam logic [1:0] CFG_MODULE_HDR_WRD = 2'd2;
  localparam logic [1:0] CFG_CHANNELS       = 2'd3;

  localparam logic [7:0] ERR_OK      = 8'd0;
  localparam logic [7:0] ERR_BENIGN  = 8'd2;

  typedef struct packed {
    logic              done;
    logic [DVR_W-1:0]  rem;
    logic [QSAT_W-1:0] quo;
  } div_res_t;

endpackage

// ===== rtl/dpp_div.sv =====
// Restoring divider that splits a byte offset into module index and offset in block.
module dpp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dpp_pkg::DVD_W-1:0]  dividend,
  input  logic [dpp_pkg::DVR_W-1:0]  divisor,
  output dpp_pkg::div_res_t          res
);
  import dpp_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVR_W-1:0] rem_r;
  logic [DVR_W:0]   trial;
  logic             fits;
  logic [DVR_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_STEPS;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;
  assign res.quo  = (|quo_r[DVD_W-1:QSAT_W-1]) ? MOD_LIMIT : quo_r[QSAT_W-1:0];

endmodule

// ===== rtl/detector_event_packet_parser.sv =====
// Detector event packet parser: byte stream in, channel samples and packet status out.
// A byte's result is in the output register in the cycle after the byte is accepted.
// Throughput: one byte per cycle while results are taken and no configuration write is offered.
// After reset and after each configuration write the block takes no byte while
// the 16-step divider re-derives the module position from the byte position.
// Reset is synchronous, active low; it returns to the start of a packet.
module detector_event_packet_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [4:0]         out_module_index,
  output logic [9:0]         out_channel_index,
  output logic signed [11:0] out_sample_value,
  output logic [31:0]        out_event_time,
  output logic [7:0]         out_error_code,
  output logic [16:0]        out_min_delta_time,
  output logic               out_skipped,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import dpp_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [1:0]  state_r, state_nxt;

  logic [7:0]  hdr_bytes_r;
  logic [5:0]  mod_count_r;
  logic [5:0]  mod_hdr_words_r;
  logic [10:0] channels_r;

  logic [DVR_W-1:0]  block_r;
  logic [16:0]       len_r;
  logic [QSAT_W-1:0] effm_r;

  logic [15:0]       pos_r;
  logic [DVR_W-1:0]  rem_r;
  logic [QSAT_W-1:0] quo_r;
  logic [7:0]        low_hold_r;
  logic [7:0]        err_r;
  logic [31:0]       time_r;
  logic [16:0]       dmin_r;
  logic              skip_r;

  logic              div_start;
  div_res_t          div_res;

  logic              in_fire, out_fire, cfg_fire;

  // derived configuration
  logic [10:0]       effc;
  logic [DVR_W-1:0]  block_c;
  logic [QSAT_W-1:0] effm_c;
  logic [17:0]       prod_c;
  logic [17:0]       len_raw;

  // byte processing
  logic              final_b;
  logic [7:0]        err_c;
  logic [31:0]       time_c;
  logic [16:0]       dmin_c;
  logic              skip_c;
  logic [7:0]        low_hold_c;
  logic              body;
  logic [10:0]       w;
  logic [15:0]       word;
  logic              have_sample;
  logic [10:0]       ch_diff;
  logic [15:0]       pos_nxt;
  logic [DVR_W-1:0]  rem_inc;
  logic [DVR_W-1:0]  rem_nxt;
  logic [QSAT_W-1:0] quo_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_RUN) && !cfg_valid && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign div_start = (state_r == ST_START);

  dpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_r - {8'd0, hdr_bytes_r}),
    .divisor  (block_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (div_res.done) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_LOAD;
    endcase
    if (cfg_fire) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_LOAD;
      hdr_bytes_r     <= 8'd16;
      mod_count_r     <= 6'd1;
      mod_hdr_words_r <= 6'd4;
      channels_r      <= 11'd64;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_HEADER_BYTES:   hdr_bytes_r     <= cfg_data[7:0];
          CFG_MODULE_COUNT:   mod_count_r     <= cfg_data[5:0];
          CFG_MODULE_HDR_WRD: mod_hdr_words_r <= cfg_data[5:0];
          CFG_CHANNELS:       channels_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    effc    = (channels_r > CH_LIMIT) ? CH_LIMIT : channels_r;
    block_c = {(11'(mod_hdr_words_r) + effc), 1'b0};
    effm_c  = (mod_count_r > MOD_LIMIT) ? MOD_LIMIT : mod_count_r;
    prod_c  = 18'(effm_c) * 18'(block_c);
    len_raw = prod_c + 18'(hdr_bytes_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      block_r <= block_c;
      effm_r  <= effm_c;
      len_r   <= (len_raw > 18'(LEN_LIMIT)) ? LEN_LIMIT : len_raw[16:0];
    end
  end

  always_comb begin
    final_b    = ({1'b0, pos_r} + 17'd1) >= len_r;

    err_c      = (pos_r == 16'd0) ? 8'd0 : err_r;
    time_c     = (pos_r == 16'd0) ? 32'd0 : time_r;
    dmin_c     = (pos_r == 16'd0) ? DMIN_RESET : dmin_r;
    skip_c     = (pos_r == 16'd0) ? 1'b0 : skip_r;
    low_hold_c = low_hold_r;

    if (pos_r == 16'd4) begin
      err_c  = in_data_byte;
      skip_c = (in_data_byte != ERR_OK) && (in_data_byte != ERR_BENIGN);
    end
    if (pos_r >= 16'd8 && pos_r <= 16'd11) begin
      time_c = {time_c[23:0], in_data_byte};
    end

    body        = (pos_r >= {8'd0, hdr_bytes_r}) && (block_r != '0) && (quo_r < effm_r);
    w           = rem_r[DVR_W-1:1];
    word        = {in_data_byte, low_hold_r};
    ch_diff     = w - 11'(mod_hdr_words_r);
    have_sample = 1'b0;

    if (body) begin
      if (!rem_r[0]) begin
        low_hold_c = in_data_byte;
      end else if (w < 11'(mod_hdr_words_r)) begin
        if (w == 11'd3 && 17'(word) < dmin_c) begin
          dmin_c = 17'(word);
        end
      end else if (!skip_c) begin
        have_sample = 1'b1;
      end
    end

    // position bookkeeping for the next byte
    pos_nxt = final_b ? 16'd0 : pos_r + 16'd1;
    rem_inc = rem_r + DVR_W'(1);
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (pos_nxt == {8'd0, hdr_bytes_r}) begin
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (pos_r >= {8'd0, hdr_bytes_r}) begin
      if (rem_inc == block_r) begin
        rem_nxt = '0;
        quo_nxt = (quo_r == MOD_LIMIT) ? quo_r : quo_r + QSAT_W'(1);
      end else begin
        rem_nxt = rem_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      err_r  <= '0;
      time_r <= '0;
      dmin_r <= DMIN_RESET;
      skip_r <= 1'b0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      err_r  <= err_c;
      time_r <= time_c;
      dmin_r <= dmin_c;
      skip_r <= skip_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_hold_r <= '0;
    end else if (in_fire) begin
      low_hold_r <= low_hold_c;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && div_res.done) begin
      rem_r <= div_res.rem;
      quo_r <= div_res.quo;
    end else if (in_fire) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= final_b || have_sample;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_kind           <= final_b;
      out_module_index   <= have_sample ? quo_r[4:0] : 5'd0;
      out_channel_index  <= have_sample ? ch_diff[9:0] : 10'd0;
      out_sample_value   <= have_sample ? $signed(word[11:0]) : 12'sd0;
      out_error_code     <= err_c;
      out_last           <= final_b;
      if (final_b) begin
        out_event_time     <= skip_c ? 32'd0 : time_c;
        out_min_delta_time <= skip_c ? DMIN_RESET : dmin_c;
        out_skipped        <= skip_c;
      end else begin
        out_event_time     <= time_c;
        out_min_delta_time <= 17'd0;
        out_skipped        <= 1'b0;
      end
    end
  end

endmodule
